// File: rtl/rbsi_pkg.sv
// Package: shared types, constants and the divider step function for the slab test.
`timescale 1ns / 1ps
package rbsi_pkg;

	localparam int DIV_STAGES     = 8;
	localparam int LANES          = 6;
	localparam int PIPE_DEPTH     = DIV_STAGES + 3;

	typedef logic signed [31:0] q16_t;

	localparam q16_t T_MAX = 32'sh7FFF_FFFF;
	localparam q16_t T_MIN = 32'sh8000_0000;

	typedef enum logic [2:0] {
		IDX_A_X = 3'd0,
		IDX_A_Y = 3'd1,
		IDX_A_Z = 3'd2,
		IDX_B_X = 3'd3,
		IDX_B_Y = 3'd4,
		IDX_B_Z = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic ovf;
		logic neg;
	} div_flags_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [3:0]  q;
	} step_t;

	// Four restoring division steps; rem stays below d.
	function automatic step_t div_step4(input logic [31:0] rem, input logic [31:0] d,
			input logic [3:0] nb);
		step_t       res;
		logic [32:0] r;
		res.rem = rem;
		res.q   = 4'd0;
		for (int k = 0; k < 4; k++) begin
			r = {res.rem, nb[3-k]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				res.q[3-k] = 1'b1;
			end
			res.rem = r[31:0];
		end
		return res;
	endfunction

endpackage

// File: rtl/rbsi_div.sv
// Pipelined restoring divider: 33-bit magnitude shifted by 16 over a 32-bit magnitude.
`timescale 1ns / 1ps
module rbsi_div (
	input  logic                          clk,
	input  logic [rbsi_pkg::DIV_STAGES-1:0] en,
	input  logic [32:0]                   mn,
	input  logic [31:0]                   md,
	input  logic                          neg,
	output logic [31:0]                   quo,
	output rbsi_pkg::div_flags_t          flags
);
	import rbsi_pkg::*;

	logic [31:0] rem_s [DIV_STAGES];
	logic [31:0] quo_s [DIV_STAGES];
	logic [31:0] nlo_s [DIV_STAGES];
	logic [31:0] md_s  [DIV_STAGES];
	div_flags_t  flg_s [DIV_STAGES];

	genvar j;
	generate
		for (j = 0; j < DIV_STAGES; j++) begin : g_stage
			logic [31:0] rem_in, quo_in, nlo_in, md_in;
			div_flags_t  flg_in;
			step_t       st;
			if (j == 0) begin : g_first
				always_comb begin
					rem_in     = {15'd0, mn[32:16]};
					quo_in     = 32'd0;
					nlo_in     = {mn[15:0], 16'd0};
					md_in      = md;
					// quotient of 2^32 or more saturates in any case
					flg_in.ovf = ({15'd0, mn[32:16]} >= md);
					flg_in.neg = neg;
				end
			end else begin : g_next
				always_comb begin
					rem_in = rem_s[j-1];
					quo_in = quo_s[j-1];
					nlo_in = nlo_s[j-1];
					md_in  = md_s[j-1];
					flg_in = flg_s[j-1];
				end
			end
			assign st = div_step4(rem_in, md_in, nlo_in[31:28]);
			always_ff @(posedge clk) begin
				if (en[j]) begin
					rem_s[j] <= st.rem;
					quo_s[j] <= {quo_in[27:0], st.q};
					nlo_s[j] <= {nlo_in[27:0], 4'd0};
					md_s[j]  <= md_in;
					flg_s[j] <= flg_in;
				end
			end
		end
	endgenerate

	assign quo   = quo_s[DIV_STAGES-1];
	assign flags = flg_s[DIV_STAGES-1];
endmodule

// File: rtl/ray_box_slab_intersect_unit.sv
// Top level: ray versus axis-aligned box slab test, fully pipelined.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  input    | in_valid / in_stall   | origin_x/y/z, dir_x/y/z (signed Q16.16)
//  output   | out_valid / out_stall | hit, near_distance (unsigned Q15.16)
//  config   | cfg_wr_en             | cfg_index, cfg_data
//
// One request per cycle while out_stall is low; stages in order: differences,
// the six parallel dividers at four quotient bits per stage, saturation and
// slab ordering, then interval narrowing into the output register.
// Reset clears valid bits and loads corners to -0.5 and +0.5.
// Each stage holds only while it is full and the stage after it holds, so
// bubbles close up under a stall and nothing is lost or repeated.
module ray_box_slab_intersect_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic [30:0]        near_distance
);
	import rbsi_pkg::*;

	q16_t corner_q [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < 3; l++) begin
				corner_q[l]   <= -32'sd32768;
				corner_q[l+3] <= 32'sd32768;
			end
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				IDX_A_X: corner_q[0] <= cfg_data;
				IDX_A_Y: corner_q[1] <= cfg_data;
				IDX_A_Z: corner_q[2] <= cfg_data;
				IDX_B_X: corner_q[3] <= cfg_data;
				IDX_B_Y: corner_q[4] <= cfg_data;
				IDX_B_Z: corner_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage advance chain
	logic [PIPE_DEPTH-1:0] v_q;
	logic [PIPE_DEPTH-1:0] en;

	always_comb begin
		en[PIPE_DEPTH-1] = !v_q[PIPE_DEPTH-1] || !out_stall;
		for (int k = PIPE_DEPTH - 2; k >= 0; k--)
			en[k] = !v_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0])
				v_q[0] <= in_valid;
			for (int k = 1; k < PIPE_DEPTH; k++)
				if (en[k])
					v_q[k] <= v_q[k-1];
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = v_q[PIPE_DEPTH-1];

	// stage 1: differences and magnitudes
	q16_t        org [3];
	q16_t        dir [3];
	logic [32:0] mn_s1  [LANES];
	logic [31:0] md_s1  [LANES];
	logic        neg_s1 [LANES];

	always_comb begin
		org[0] = origin_x;
		org[1] = origin_y;
		org[2] = origin_z;
		dir[0] = dir_x;
		dir[1] = dir_y;
		dir[2] = dir_z;
	end

	logic [31:0] quo   [LANES];
	div_flags_t  flags [LANES];
	q16_t        t_sat [LANES];

	genvar l;
	generate
		for (l = 0; l < LANES; l++) begin : g_lane
			logic signed [32:0] diff;
			q16_t               dfix;
			always_comb begin
				diff = 33'(corner_q[l]) - 33'(org[l % 3]);
				// zero direction becomes one LSB
				dfix = (dir[l % 3] == 32'sd0) ? 32'sd1 : dir[l % 3];
			end
			always_ff @(posedge clk) begin
				if (en[0]) begin
					mn_s1[l]  <= diff[32] ? 33'(-diff) : 33'(diff);
					md_s1[l]  <= dfix[31] ? 32'(-dfix) : 32'(dfix);
					neg_s1[l] <= diff[32] ^ dfix[31];
				end
			end

			rbsi_div u_div (
				.clk   (clk),
				.en    (en[DIV_STAGES:1]),
				.mn    (mn_s1[l]),
				.md    (md_s1[l]),
				.neg   (neg_s1[l]),
				.quo   (quo[l]),
				.flags (flags[l])
			);

			always_comb begin
				if (flags[l].neg) begin
					if (flags[l].ovf || quo[l] > 32'h8000_0000)
						t_sat[l] = T_MIN;
					else
						t_sat[l] = q16_t'(-quo[l]);
				end else begin
					if (flags[l].ovf || quo[l] > 32'h7FFF_FFFF)
						t_sat[l] = T_MAX;
					else
						t_sat[l] = q16_t'(quo[l]);
				end
			end
		end
	endgenerate

	// saturate and order each slab
	q16_t lo_s10 [3];
	q16_t hi_s10 [3];

	always_ff @(posedge clk) begin
		if (en[DIV_STAGES+1]) begin
			for (int a = 0; a < 3; a++) begin
				if (t_sat[a] > t_sat[a+3]) begin
					lo_s10[a] <= t_sat[a+3];
					hi_s10[a] <= t_sat[a];
				end else begin
					lo_s10[a] <= t_sat[a];
					hi_s10[a] <= t_sat[a+3];
				end
			end
		end
	end

	// narrow the interval; it only shrinks, so one final test matches early exit
	q16_t lo_c, hi_c;

	always_comb begin
		lo_c = 32'sd0;
		hi_c = T_MAX;
		for (int a = 0; a < 3; a++) begin
			if (lo_s10[a] > lo_c)
				lo_c = lo_s10[a];
			if (hi_s10[a] < hi_c)
				hi_c = hi_s10[a];
		end
	end

	always_ff @(posedge clk) begin
		if (en[PIPE_DEPTH-1]) begin
			hit           <= !(lo_c > hi_c);
			near_distance <= (lo_c > hi_c) ? 31'd0 : lo_c[30:0];
		end
	end
endmodule
